// ===== hdl/ft12_link_frame_receiver_assert.svh =====
// Assertion helpers; the enclosing module provides clk and rst.
`ifndef FT12_LINK_FRAME_RECEIVER_ASSERT_SVH
`define FT12_LINK_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define FT12_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ft12 receiver check failed");

// Next-cycle implication.
`define FT12_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ft12 receiver check failed");

`endif

// ===== hdl/ft12_pkg.sv =====
`default_nettype none

package ft12_pkg;

  localparam logic [7:0] START_VARIABLE = 8'h68;
  localparam logic [7:0] START_FIXED    = 8'h10;
  localparam logic [7:0] STOP_OCTET     = 8'h16;
  localparam logic [7:0] MIN_LENGTH     = 8'd2;

  typedef enum logic [12:0] {
    PH_HUNT    = 13'b0000000000001,
    PH_F_CTRL  = 13'b0000000000010,
    PH_F_ADDR  = 13'b0000000000100,
    PH_F_SUM   = 13'b0000000001000,
    PH_F_STOP  = 13'b0000000010000,
    PH_V_LEN1  = 13'b0000000100000,
    PH_V_LEN2  = 13'b0000001000000,
    PH_V_START = 13'b0000010000000,
    PH_V_CTRL  = 13'b0000100000000,
    PH_V_ADDR  = 13'b0001000000000,
    PH_V_DATA  = 13'b0010000000000,
    PH_V_SUM   = 13'b0100000000000,
    PH_V_STOP  = 13'b1000000000000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_START    = 3'd3,
    ST_SUM      = 3'd4,
    ST_STOP     = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      item_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    status_t    status;
    logic       fixed_frame;
    logic [7:0] control;
    logic [7:0] link_address;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/ft12_link_frame_receiver.sv =====
// FT1.2 link frame receiver.
// Slave channel (s_*): one received serial octet per word in s_tdata.
// Master channel (m_*): payload words of variable frames, passed through as
// they arrive, and one frame-end status word for every frame that got past
// its start octet. m_tuser says which kind the word is; on a status other
// than ok, drop the payload already delivered for that frame.
// Path: an accepted octet waits in the input register, and the result word it
// makes is then loaded into the output register, which drives the master side.
// Throughput: one octet per cycle unless a held result stalls the input; the
// frame state update is a single registered pass, and octets that cause no
// result never wait on the output.
// Reset (rst, synchronous) empties both registers and returns to hunting for
// a start octet. When m_tready is low with a result held, the input register
// fills and s_tready drops only once an octet that needs the output arrives.
`default_nettype none

module ft12_link_frame_receiver
  import ft12_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [47:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                      // [18:16] status, [19] fixed_frame,
                                      // [27:20] control, [35:28] link_address,
                                      // [43:36] payload_length, [47:44] zero
  output      logic [0:0]  m_tuser    // [0] item_kind
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       consume;
  logic       out_free;
  result_t    result;
  result_t    out_reg;

  ft12_frame_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (consume),
    .rx_byte (in_byte),
    .result  (result)
  );

  assign out_free = !m_tvalid || m_tready;
  // Advance unless this word makes a result and the output slot is still taken.
  assign consume  = in_valid && (!result.valid || out_free);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && result.valid) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {4'b0000, out_reg.payload_length, out_reg.link_address,
                    out_reg.control, out_reg.fixed_frame, out_reg.status,
                    out_reg.byte_index, out_reg.data_byte};
  assign m_tuser = out_reg.item_kind;

`include "ft12_link_frame_receiver_assert.svh"

  `FT12_ASSERT_NEXT(a_in_hold, in_valid && !consume, in_valid && $stable(in_byte))
  `FT12_ASSERT_NEXT(a_result_loaded, consume && result.valid, m_tvalid)
  `FT12_ASSERT_NOW(a_payload_clean, m_tvalid && (m_tuser == KIND_PAYLOAD), m_tdata[47:16] == 32'd0)

endmodule

`default_nettype wire

// ===== hdl/ft12_frame_core.sv =====
`default_nettype none

module ft12_frame_core
  import ft12_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] held_control, held_control_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] octet_count, octet_count_next;
  logic       is_fixed, is_fixed_next;

  logic       end_frame;
  status_t    end_code;
  logic       header_known;
  logic [7:0] sum_with_byte;
  logic [7:0] count_inc;
  logic [7:0] length_less2;

  assign sum_with_byte = running_sum + rx_byte;
  assign count_inc     = octet_count + 8'd1;
  assign length_less2  = frame_length - MIN_LENGTH;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    held_control_next = held_control;
    held_address_next = held_address;
    running_sum_next  = running_sum;
    octet_count_next  = octet_count;
    is_fixed_next     = is_fixed;
    end_frame         = 1'b0;
    end_code          = ST_OK;
    result            = '0;

    unique case (phase)
      PH_F_CTRL: begin
        held_control_next = rx_byte;
        running_sum_next  = rx_byte;
        phase_next        = PH_F_ADDR;
      end
      PH_F_ADDR: begin
        held_address_next = rx_byte;
        running_sum_next  = sum_with_byte;
        phase_next        = PH_F_SUM;
      end
      PH_F_SUM: begin
        if (rx_byte != running_sum) begin
          end_frame = 1'b1;
          end_code  = ST_SUM;
        end else begin
          phase_next = PH_F_STOP;
        end
      end
      PH_F_STOP, PH_V_STOP: begin
        end_frame = 1'b1;
        end_code  = (rx_byte == STOP_OCTET) ? ST_OK : ST_STOP;
      end
      PH_V_LEN1: begin
        frame_length_next = rx_byte;
        if (rx_byte < MIN_LENGTH) begin
          end_frame = 1'b1;
          end_code  = ST_SHORT;
        end else begin
          phase_next = PH_V_LEN2;
        end
      end
      PH_V_LEN2: begin
        if (rx_byte != frame_length) begin
          end_frame = 1'b1;
          end_code  = ST_MISMATCH;
        end else begin
          phase_next = PH_V_START;
        end
      end
      PH_V_START: begin
        if (rx_byte != START_VARIABLE) begin
          end_frame = 1'b1;
          end_code  = ST_START;
        end else begin
          phase_next = PH_V_CTRL;
        end
      end
      PH_V_CTRL: begin
        held_control_next = rx_byte;
        running_sum_next  = rx_byte;
        phase_next        = PH_V_ADDR;
      end
      PH_V_ADDR: begin
        held_address_next = rx_byte;
        running_sum_next  = sum_with_byte;
        octet_count_next  = '0;
        phase_next        = (frame_length == MIN_LENGTH) ? PH_V_SUM : PH_V_DATA;
      end
      PH_V_DATA: begin
        // Pass the payload word straight through.
        result.valid      = 1'b1;
        result.item_kind  = KIND_PAYLOAD;
        result.data_byte  = rx_byte;
        result.byte_index = octet_count;
        running_sum_next  = sum_with_byte;
        octet_count_next  = count_inc;
        if (count_inc == length_less2) begin
          phase_next = PH_V_SUM;
        end
      end
      PH_V_SUM: begin
        if (rx_byte != running_sum) begin
          end_frame = 1'b1;
          end_code  = ST_SUM;
        end else begin
          phase_next = PH_V_STOP;
        end
      end
      default: begin
        // Hunt; unused codes land here too.
        phase_next = PH_HUNT;
        if (rx_byte == START_FIXED) begin
          is_fixed_next     = 1'b1;
          held_control_next = '0;
          held_address_next = '0;
          frame_length_next = '0;
          phase_next        = PH_F_CTRL;
        end else if (rx_byte == START_VARIABLE) begin
          is_fixed_next     = 1'b0;
          held_control_next = '0;
          held_address_next = '0;
          phase_next        = PH_V_LEN1;
        end
      end
    endcase

    header_known = !(end_code == ST_SHORT || end_code == ST_MISMATCH ||
                     end_code == ST_START);

    if (end_frame) begin
      // Drop the offending word and go back to hunting.
      phase_next            = PH_HUNT;
      result.valid          = 1'b1;
      result.item_kind      = KIND_STATUS;
      result.status         = end_code;
      result.fixed_frame    = is_fixed;
      result.control        = header_known ? held_control : 8'd0;
      result.link_address   = header_known ? held_address : 8'd0;
      result.payload_length = (header_known && !is_fixed) ? length_less2 : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      held_control <= '0;
      held_address <= '0;
      running_sum  <= '0;
      octet_count  <= '0;
      is_fixed     <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      held_control <= held_control_next;
      held_address <= held_address_next;
      running_sum  <= running_sum_next;
      octet_count  <= octet_count_next;
      is_fixed     <= is_fixed_next;
    end
  end

endmodule

`default_nettype wire
